// ===== hdl/ssdt_pkg.sv =====
// shared constants and types for the sorted set disjointness tester
`default_nettype none
package ssdt_pkg;

    localparam int unsigned SET_IDX_W = 10;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned RANK_IN_W = 16;
    localparam int unsigned SIZE_W    = 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    localparam logic [SIZE_W-1:0] ROW_LEN_RST = 8'd17;

    typedef struct packed {
        logic hit;
        logic done;
    } t_merge_stat;

endpackage
`default_nettype wire

// ===== hdl/ssdt_if.sv =====
// valid/ready channel interfaces for input items and result items
`default_nettype none
interface ssdt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [ssdt_pkg::SET_IDX_W-1:0] set_index;
    logic [ssdt_pkg::POS_W-1:0]     position;
    logic [ssdt_pkg::RANK_IN_W-1:0] line_rank;
    logic [ssdt_pkg::SET_IDX_W-1:0] other_set;

    modport source (output valid, output func, output set_index, output position,
                    output line_rank, output other_set, input ready);
    modport sink   (input valid, input func, input set_index, input position,
                    input line_rank, input other_set, output ready);
endinterface

interface ssdt_out_if;
    logic valid;
    logic ready;
    logic disjoint;

    modport source (output valid, output disjoint, input ready);
    modport sink   (input valid, input disjoint, output ready);
endinterface
`default_nettype wire

// ===== hdl/ssdt_ram.sv =====
// generic ram, one write port, two registered read ports
`default_nettype none
module ssdt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 131072
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// ===== hdl/ssdt_merge.sv =====
// two-cursor merge step unit: one compare per cycle, picks next read positions
`default_nettype none
module ssdt_merge #(
    parameter int unsigned MAX_SET_SIZE = 128,
    parameter int unsigned RANK_BITS    = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic                              i_step,
    input  wire logic [$clog2(MAX_SET_SIZE+1)-1:0] i_n,
    input  wire logic [RANK_BITS-1:0]              i_x,
    input  wire logic [RANK_BITS-1:0]              i_y,
    output logic      [$clog2(MAX_SET_SIZE+1)-1:0] o_u_rd,
    output logic      [$clog2(MAX_SET_SIZE+1)-1:0] o_v_rd,
    output ssdt_pkg::t_merge_stat                  o_stat
);

    localparam int unsigned CW = $clog2(MAX_SET_SIZE + 1);

    logic [CW-1:0] r_u;
    logic [CW-1:0] r_v;
    logic [CW-1:0] n_u;
    logic [CW-1:0] n_v;
    logic          w_eq;
    logic          w_lt;

    assign w_eq = (i_x == i_y);
    assign w_lt = (i_x < i_y);

    always_comb begin
        n_u = r_u;
        n_v = r_v;
        if (i_start) begin
            n_u = '0;
            n_v = '0;
        end else if (i_step) begin
            // advance the cursor sitting on the smaller element
            if (w_lt) begin
                n_u = r_u + CW'(1);
            end else begin
                n_v = r_v + CW'(1);
            end
        end
    end

    assign o_u_rd      = n_u;
    assign o_v_rd      = n_v;
    assign o_stat.hit  = i_step & w_eq;
    assign o_stat.done = i_step & (w_eq | (n_u == i_n) | (n_v == i_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u <= '0;
            r_v <= '0;
        end else begin
            r_u <= n_u;
            r_v <= n_v;
        end
    end

`ifndef SYNTHESIS
    a_cursor_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (r_u < i_n) && (r_v < i_n))
        else $error("merge cursor past end of set");

    a_one_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !o_stat.done |=>
        ({1'b0, r_u} + {1'b0, r_v}) == ($past({1'b0, r_u} + {1'b0, r_v}) + (CW+1)'(1)))
        else $error("merge step did not advance exactly one cursor");
`endif

endmodule
`default_nettype wire

// ===== hdl/sorted_set_disjointness_test.sv =====
// top level: set store, sequencer and result register of the disjointness tester
//
// channel     dir   handshake      payload
// i_item      in    valid/ready    func, set_index, position, line_rank, other_set
// o_result    out   valid/ready    disjoint
// i_cfg_*     in    write enable   row_len
//
// a load item passes the reduction, base and fetch states; a test item also
// runs up to 2*min(row_len,MAX_SET_SIZE)-1 merge steps, one compare per cycle on
// the dual-read store; row reduction repeats when NUM_SETS is below 1024
// reset (synchronous, active low) clears the sequencer and sets row_len to 17;
// the store is not cleared
// the result register lets a new item in while a result waits; a second result
// waits in the sequencer until the first one is taken
`default_nettype none
module sorted_set_disjointness_test #(
    parameter int unsigned NUM_SETS     = 1024,
    parameter int unsigned MAX_SET_SIZE = 128,
    parameter int unsigned RANK_BITS    = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ssdt_pkg::SIZE_W-1:0] i_cfg_wdata,
    ssdt_in_if.sink                          i_item,
    ssdt_out_if.source                       o_result
);

    localparam int unsigned DEPTH = NUM_SETS * MAX_SET_SIZE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned ROW_W = $clog2(NUM_SETS);
    localparam int unsigned CW    = $clog2(MAX_SET_SIZE + 1);
    localparam int unsigned IW    = ssdt_pkg::SET_IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;
    localparam logic [2:0] S_BASE  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [ssdt_pkg::SIZE_W-1:0]   r_row_len;
    logic                          r_ovalid;
    logic                          n_ovalid;
    logic                          r_odisj;
    logic                          r_res;
    logic                          n_res;
    logic                          r_func;
    logic [IW-1:0]                 r_ra;
    logic [IW-1:0]                 r_rb;
    logic [ssdt_pkg::POS_W-1:0]    r_pos;
    logic [RANK_BITS-1:0]          r_rank;
    logic [CW-1:0]                 r_n;
    logic [AW-1:0]                 r_base_a;
    logic [AW-1:0]                 r_base_b;

    logic                          w_accept;
    logic                          w_emit;
    logic [31:0]                   w_ra_ext;
    logic [31:0]                   w_rb_ext;
    logic                          w_ra_big;
    logic                          w_rb_big;
    logic [AW-1:0]                 w_base_a;
    logic [AW-1:0]                 w_base_b;
    logic [31:0]                   w_size_ext;
    logic [31:0]                   w_n_eff;
    logic [31:0]                   w_rank_ext;
    logic                          w_pos_ok;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [AW-1:0]                 w_raddr_a;
    logic [AW-1:0]                 w_raddr_b;
    logic [RANK_BITS-1:0]          w_x;
    logic [RANK_BITS-1:0]          w_y;
    logic [CW-1:0]                 w_u_rd;
    logic [CW-1:0]                 w_v_rd;
    ssdt_pkg::t_merge_stat         w_stat;

    assign i_item.ready      = (r_state == S_IDLE);
    assign w_accept          = i_item.valid & i_item.ready;
    assign o_result.valid    = r_ovalid;
    assign o_result.disjoint = r_odisj;

    // row index modulo NUM_SETS by repeated subtract
    assign w_ra_ext = 32'(r_ra);
    assign w_rb_ext = 32'(r_rb);
    assign w_ra_big = (w_ra_ext >= NUM_SETS);
    assign w_rb_big = (w_rb_ext >= NUM_SETS);

    assign w_base_a = AW'(w_ra_ext[ROW_W-1:0]) * AW'(MAX_SET_SIZE);
    assign w_base_b = AW'(w_rb_ext[ROW_W-1:0]) * AW'(MAX_SET_SIZE);

    assign w_size_ext = 32'(r_row_len);
    assign w_n_eff    = (w_size_ext > MAX_SET_SIZE) ? 32'(MAX_SET_SIZE) : w_size_ext;
    assign w_rank_ext = 32'(i_item.line_rank);

    assign w_pos_ok  = (32'(r_pos) < MAX_SET_SIZE);
    assign w_we      = (r_state == S_FETCH) && (r_func == ssdt_pkg::FUNC_LOAD) && w_pos_ok;
    assign w_waddr   = r_base_a + AW'(r_pos);
    assign w_raddr_a = r_base_a + AW'(w_u_rd);
    assign w_raddr_b = r_base_b + AW'(w_v_rd);

    assign w_emit = (r_state == S_EMIT) && (!r_ovalid || o_result.ready);

    ssdt_ram #(
        .WIDTH (RANK_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (r_rank),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_x),
        .o_rdata_b (w_y)
    );

    ssdt_merge #(
        .MAX_SET_SIZE (MAX_SET_SIZE),
        .RANK_BITS    (RANK_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_FETCH),
        .i_step  (r_state == S_MERGE),
        .i_n     (r_n),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_u_rd  (w_u_rd),
        .o_v_rd  (w_v_rd),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (!w_ra_big && !w_rb_big) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (r_func == ssdt_pkg::FUNC_LOAD) begin
                    n_state = S_IDLE;
                end else if (r_n == '0) begin
                    // empty sets never meet
                    n_res   = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (w_stat.done) begin
                    n_res   = ~w_stat.hit;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_emit) begin
            n_ovalid = 1'b1;
        end else if (o_result.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_row_len <= ssdt_pkg::ROW_LEN_RST;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_row_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_emit) begin
            r_odisj <= r_res;
        end
        if (w_accept) begin
            r_func <= i_item.func;
            r_ra   <= i_item.set_index;
            r_rb   <= i_item.other_set;
            r_pos  <= i_item.position;
            r_rank <= w_rank_ext[RANK_BITS-1:0];
            r_n    <= w_n_eff[CW-1:0];
        end else if (r_state == S_RED) begin
            if (w_ra_big) begin
                r_ra <= IW'(w_ra_ext - NUM_SETS);
            end
            if (w_rb_big) begin
                r_rb <= IW'(w_rb_ext - NUM_SETS);
            end
        end
        if (r_state == S_BASE) begin
            r_base_a <= w_base_a;
            r_base_b <= w_base_b;
        end
    end

`ifndef SYNTHESIS
    a_rows_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BASE) |-> (w_ra_ext < NUM_SETS) && (w_rb_ext < NUM_SETS))
        else $error("row index not reduced before address computation");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && ($past(r_state) != S_EMIT) |->
        ($past(r_state) == S_MERGE) || ($past(r_state) == S_FETCH))
        else $error("result produced without a test item");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_sorted_set_disjointness_test.sv =====
// testbench for the disjointness tester: directed table, then random size phases checked by a merge predictor
module tb_sorted_set_disjointness_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_SETS     = 1024;
    localparam int unsigned MAX_SET_SIZE = 128;
    localparam int unsigned STORE_DEPTH  = NUM_SETS * MAX_SET_SIZE;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 60;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned NUM_PHASES   = 12;
    localparam int unsigned NUM_DIRECTED = 25;

    typedef logic [ssdt_pkg::SET_IDX_W-1:0] t_row;
    typedef logic [ssdt_pkg::RANK_IN_W-1:0] t_rank;
    typedef logic [ssdt_pkg::POS_W-1:0]     t_pos;
    typedef logic [ssdt_pkg::SIZE_W-1:0]    t_size;

    typedef struct packed {
        t_size size;
        logic  func;
        t_row  set_index;
        t_pos  position;
        t_rank line_rank;
        t_row  other_set;
        logic  typed;
        logic  disjoint;
    } t_dir_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_size i_cfg_wdata;

    ssdt_in_if  item_if ();
    ssdt_out_if result_if ();

    sorted_set_disjointness_test u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the set store and of the row length
    t_rank rank_copy [STORE_DEPTH];
    bit    rank_known [STORE_DEPTH];
    bit    row_listed [NUM_SETS];
    t_size size_copy;

    bit          expected_disjoint_q [$];
    int          known_rows [$];
    int unsigned fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    bit          sender_calm   = 1'b0;
    bit          receiver_calm = 1'b0;
    bit          hold_done     = 1'b0;

    function automatic int unsigned active_size();
        return (size_copy > MAX_SET_SIZE) ? MAX_SET_SIZE : int'(size_copy);
    endfunction

    function automatic int unsigned slot(t_row row, int unsigned pos);
        return (int'(row) % NUM_SETS) * MAX_SET_SIZE + pos;
    endfunction

    // two-cursor merge, stops at the first common element or as soon as either set runs out
    function automatic bit predict_disjoint(t_row row_a, t_row row_b);
        int unsigned n;
        int unsigned u;
        int unsigned v;
        t_rank       x;
        t_rank       y;
        n = active_size();
        u = 0;
        v = 0;
        while (u < n && v < n) begin
            x = rank_copy[slot(row_a, u)];
            y = rank_copy[slot(row_b, v)];
            if (x == y) return 1'b0;
            if (x < y) u++;
            else v++;
        end
        return 1'b1;
    endfunction

    function automatic bit row_filled(int row, int unsigned n);
        for (int unsigned p = 0; p < n; p++) begin
            if (!rank_known[slot(t_row'(row), p)]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int count_filled_rows(int unsigned n);
        int cnt;
        cnt = 0;
        foreach (known_rows[k]) begin
            if (row_filled(known_rows[k], n)) cnt++;
        end
        return cnt;
    endfunction

    // rows whose first n entries are all written, so a test never reads garbage
    function automatic int pick_filled_row(int unsigned n);
        int cands [$];
        foreach (known_rows[k]) begin
            if (row_filled(known_rows[k], n)) cands.push_back(known_rows[k]);
        end
        if (cands.size() == 0) return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    function automatic int unsigned random_gap(bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    task automatic send_item(logic func, t_row set_index, t_pos position, t_rank line_rank,
                             t_row other_set, bit typed, bit typed_disjoint);
        int unsigned gap;
        int unsigned addr;
        gap = random_gap(sender_calm);
        if (gap != 0) begin
            item_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.func      = func;
        item_if.set_index = set_index;
        item_if.position  = position;
        item_if.line_rank = line_rank;
        item_if.other_set = other_set;
        item_if.valid     = 1'b1;
        do @(posedge i_clk); while (!item_if.ready);
        if (func == ssdt_pkg::FUNC_LOAD) begin
            addr = slot(set_index, 32'(position));
            rank_copy[addr]  = line_rank;
            rank_known[addr] = 1'b1;
            if (!row_listed[set_index]) begin
                row_listed[set_index] = 1'b1;
                known_rows.push_back(int'(set_index));
            end
        end else begin
            expected_disjoint_q.push_back(typed ? typed_disjoint
                                                : predict_disjoint(set_index, other_set));
        end
        items_sent++;
        if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
        @(negedge i_clk);
    endtask

    task automatic write_row_len(t_size value);
        item_if.valid = 1'b0;
        while (expected_disjoint_q.size() != 0) @(negedge i_clk);
        // a trailing load may still be in flight
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        size_copy = value;
    endtask

    task automatic load_row(int row, int unsigned n);
        t_rank       vals [$];
        int          src;
        int unsigned style;
        int unsigned step_max;
        int unsigned acc;
        style = $urandom_range(0, 9);
        src   = pick_filled_row(n);
        if (style inside {6, 7} && src < 0) style = 0;
        case (style)
            6, 7: begin
                // near copy of another row, shares about half its elements
                for (int unsigned p = 0; p < n; p++)
                    vals.push_back(rank_copy[slot(t_row'(src), p)] +
                                   t_rank'($urandom_range(0, 1)));
            end
            8: begin
                // unsorted, small values
                for (int unsigned p = 0; p < n; p++)
                    vals.push_back(t_rank'($urandom_range(0, 15)));
            end
            9: begin
                for (int unsigned p = 0; p < n; p++)
                    vals.push_back(t_rank'($urandom_range(0, 16'hFFFF)));
                vals.sort();
            end
            default: begin
                step_max = (style < 3) ? 3 : ((style == 3) ? 40 : 1500);
                acc      = (style == 5) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 50);
                for (int unsigned p = 0; p < n; p++) begin
                    vals.push_back(acc[ssdt_pkg::RANK_IN_W-1:0]);
                    acc = acc + $urandom_range(1, step_max);
                    if (acc > 16'hFFFF) acc = 16'hFFFF;
                end
            end
        endcase
        for (int unsigned p = 0; p < n; p++)
            send_item(ssdt_pkg::FUNC_LOAD, t_row'(row), t_pos'(p), vals[p],
                      t_row'($urandom_range(0, NUM_SETS - 1)), 1'b0, 1'b0);
    endtask

    task automatic run_phase(t_size size, int unsigned budget);
        int unsigned n;
        int unsigned stop_at;
        int unsigned r;
        int          row_a;
        int          row_b;
        write_row_len(size);
        n       = active_size();
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            r     = $urandom_range(0, 99);
            row_a = (n == 0) ? int'($urandom_range(0, NUM_SETS - 1)) : pick_filled_row(n);
            if (r < 8) begin
                send_item(ssdt_pkg::FUNC_LOAD, t_row'($urandom_range(0, NUM_SETS - 1)),
                          t_pos'($urandom_range(0, MAX_SET_SIZE - 1)),
                          t_rank'($urandom_range(0, 16'hFFFF)),
                          t_row'($urandom_range(0, NUM_SETS - 1)), 1'b0, 1'b0);
            end else if (n != 0 && (row_a < 0 || (n <= 20 && r < 38) ||
                                    (n > 20 && count_filled_rows(n) < 3))) begin
                load_row($urandom_range(0, NUM_SETS - 1), n);
            end else begin
                if (n == 0) row_b = $urandom_range(0, NUM_SETS - 1);
                else if ($urandom_range(0, 9) == 0) row_b = row_a;
                else row_b = pick_filled_row(n);
                send_item(ssdt_pkg::FUNC_TEST, t_row'(row_a),
                          t_pos'($urandom_range(0, MAX_SET_SIZE - 1)),
                          t_rank'($urandom_range(0, 16'hFFFF)), t_row'(row_b), 1'b0, 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        t_dir_row    dir_tab [NUM_DIRECTED];
        t_size       phase_size [NUM_PHASES];
        int unsigned phase_budget [NUM_PHASES];

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        item_if.valid     = 1'b0;
        item_if.func      = ssdt_pkg::FUNC_LOAD;
        item_if.set_index = '0;
        item_if.position  = '0;
        item_if.line_rank = '0;
        item_if.other_set = '0;
        size_copy         = ssdt_pkg::ROW_LEN_RST;

        dir_tab = '{
            // row 1023 at the reset row length: zero, each single rank bit from 0 to 14, all ones
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd0,  16'h0000, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd1,  16'h0001, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd2,  16'h0002, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd3,  16'h0004, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd4,  16'h0008, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd5,  16'h0010, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd6,  16'h0020, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd7,  16'h0040, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd8,  16'h0080, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd9,  16'h0100, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd10, 16'h0200, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd11, 16'h0400, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd12, 16'h0800, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd13, 16'h1000, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd14, 16'h2000, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd15, 16'h4000, 10'd0, 1'b0, 1'b0},
            '{8'd17, ssdt_pkg::FUNC_LOAD, 10'd1023, 7'd16, 16'hFFFF, 10'd0, 1'b0, 1'b0},
            // a row against itself always meets
            '{8'd17, ssdt_pkg::FUNC_TEST, 10'd1023, 7'd127, 16'hFFFF, 10'd1023, 1'b1, 1'b0},
            // empty sets never meet, rows not even read
            '{8'd0,  ssdt_pkg::FUNC_TEST, 10'd0,    7'h55,  16'hAAAA, 10'd341,  1'b1, 1'b1},
            '{8'd1,  ssdt_pkg::FUNC_LOAD, 10'd0,    7'd0,   16'hFFFF, 10'd682,  1'b0, 1'b0},
            '{8'd1,  ssdt_pkg::FUNC_LOAD, 10'd512,  7'd0,   16'hFFFF, 10'd0,    1'b0, 1'b0},
            '{8'd1,  ssdt_pkg::FUNC_TEST, 10'd0,    7'd0,   16'h0000, 10'd512,  1'b1, 1'b0},
            '{8'd1,  ssdt_pkg::FUNC_LOAD, 10'd512,  7'd0,   16'h0000, 10'd1023, 1'b0, 1'b0},
            '{8'd1,  ssdt_pkg::FUNC_TEST, 10'd0,    7'd0,   16'h0000, 10'd512,  1'b1, 1'b1},
            '{8'd1,  ssdt_pkg::FUNC_TEST, 10'd1023, 7'd0,   16'h0000, 10'd512,  1'b1, 1'b0}
        };
        // 255 and 200 clamp to the full row length
        phase_size   = '{8'd3, 8'd1, 8'd17, 8'd6, 8'd2, 8'd128, 8'd255, 8'd200,
                         8'd0, 8'd5, 8'd9, 8'd4};
        phase_budget = '{120, 100, 120, 120, 100, 450, 40, 40, 30, 120, 120, 110};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].size != size_copy) write_row_len(dir_tab[k].size);
            send_item(dir_tab[k].func, dir_tab[k].set_index, dir_tab[k].position,
                      dir_tab[k].line_rank, dir_tab[k].other_set, dir_tab[k].typed,
                      dir_tab[k].disjoint);
        end

        foreach (phase_size[k]) run_phase(phase_size[k], phase_budget[k]);

        item_if.valid = 1'b0;
        while (expected_disjoint_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        stall           = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n) begin
                // one long hold-off so the block backs up into its input
                if (!hold_done && results_seen >= HOLD_AFTER) begin
                    hold_done       = 1'b1;
                    result_if.ready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                if (stall != 0) begin
                    result_if.ready = 1'b0;
                    stall--;
                end else begin
                    result_if.ready = 1'b1;
                    stall = random_gap(receiver_calm);
                end
                if ($urandom_range(0, 99) == 0) receiver_calm = !receiver_calm;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        bit want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            results_seen++;
            if (expected_disjoint_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got disjoint=%0b",
                         $time, result_if.disjoint);
            end else begin
                want = expected_disjoint_q.pop_front();
                if (result_if.disjoint !== want) begin
                    fail_count++;
                    $display("%0t: disjoint mismatch, expected %0b, got %0b",
                             $time, want, result_if.disjoint);
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ssdt_pkg.sv
hdl/ssdt_if.sv
hdl/ssdt_ram.sv
hdl/ssdt_merge.sv
hdl/sorted_set_disjointness_test.sv
bench/tb_sorted_set_disjointness_test.sv
